[src/ttl_lookup_cache_rr_evict_top_defines.svh]
// ----------------------------------------------------------------------------
// TTL location cache - assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TTL_LOOKUP_CACHE_RR_EVICT_TOP_DEFINES_SVH
`define TTL_LOOKUP_CACHE_RR_EVICT_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TTLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttlc check failed");

// next-cycle implication, disabled while in reset
`define TTLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttlc check failed");

`endif

[src/ttlc_pkg.sv]
// ----------------------------------------------------------------------------
// TTL location cache - package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttlc_pkg;

  // storage sizes
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int ID_BITS  = 8;
  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS = IDX_BITS + 1;

  // fixed port field widths
  localparam int KEY_FIELD_W = 64;
  localparam int ID_FIELD_W  = 8;
  localparam int TIME_W      = 32;

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(60);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_INVAL  = 2'd2,
    KIND_CLEAR  = 2'd3
  } ttlc_kind_t;

  typedef enum logic [1:0] {
    OC_NONE    = 2'd0,
    OC_MATCH   = 2'd1,
    OC_EXPIRED = 2'd2,
    OC_FILL    = 2'd3
  } ttlc_outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } ttlc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic start;  // reset scan counter and search flags
    logic step;   // advance the scan by one entry
    logic exec;   // write back and load the result register
  } ttlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } ttlc_stat_t;

endpackage

[src/ttlc_ctrl.sv]
// ----------------------------------------------------------------------------
// TTL location cache - controller
// Sequences accept, entry scan and write-back for one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttlc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttlc_pkg::ttlc_stat_t stat,
  output ttlc_pkg::ttlc_cmd_t  cmd
);

  ttlc_pkg::ttlc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttlc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttlc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ttlc_pkg::ST_SCAN;
      end
      ttlc_pkg::ST_SCAN: begin
        if (stat.scan_done) state_nxt = ttlc_pkg::ST_EXEC;
      end
      ttlc_pkg::ST_EXEC: begin
        if (!stat.out_busy) state_nxt = ttlc_pkg::ST_IDLE;
      end
      default: state_nxt = ttlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ttlc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.start = in_valid;
      end
      ttlc_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ttlc_pkg::ST_EXEC: begin
        // hold until the result register can take the beat
        cmd.exec = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/ttlc_dpath.sv]
// ----------------------------------------------------------------------------
// TTL location cache - datapath
// Entry store, one-entry-per-cycle match scan, write-back and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttlc_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ttlc_pkg::ttlc_cmd_t                    cmd,
  output ttlc_pkg::ttlc_stat_t                   stat,
  input  logic [1:0]                             in_kind,
  input  logic [ttlc_pkg::KEY_FIELD_W-1:0]       in_lookup_key,
  input  logic [ttlc_pkg::ID_FIELD_W-1:0]        in_primary_id,
  input  logic [ttlc_pkg::ID_FIELD_W-1:0]        in_fallback_id,
  input  logic [ttlc_pkg::TIME_W-1:0]            in_now,
  input  logic                                   cfg_wr_en,
  input  logic [ttlc_pkg::TIME_W-1:0]            cfg_wr_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic [1:0]                             out_outcome,
  output logic [ttlc_pkg::ID_FIELD_W-1:0]        out_found_primary,
  output logic [ttlc_pkg::ID_FIELD_W-1:0]        out_found_backup
);

  localparam int EN  = ttlc_pkg::ENTRIES;
  localparam int IW  = ttlc_pkg::IDX_BITS;
  localparam int CW  = ttlc_pkg::CNT_BITS;
  localparam int KW  = ttlc_pkg::KEY_BITS;
  localparam int DW  = ttlc_pkg::ID_BITS;
  localparam int TW  = ttlc_pkg::TIME_W;

  // request registers
  ttlc_pkg::ttlc_kind_t kind_r;
  logic [KW-1:0]        key_r;
  logic [DW-1:0]        pid_r, bid_r;
  logic [TW-1:0]        now_r;
  logic [TW-1:0]        ttl_r;

  // entry store
  logic [KW-1:0] mem_key   [EN];
  logic [DW-1:0] mem_pri   [EN];
  logic [DW-1:0] mem_bak   [EN];
  logic [TW-1:0] mem_stamp [EN];
  logic [EN-1:0] valid_r;
  logic [IW-1:0] evict_ptr_r;

  // scan
  logic [CW-1:0] cnt_r;
  logic          issue;
  logic [IW-1:0] rd_addr;
  logic          rd_en_r;
  logic [IW-1:0] rd_idx_r;
  logic [KW-1:0] rd_key_r;
  logic [DW-1:0] rd_pri_r, rd_bak_r;
  logic [TW-1:0] rd_stamp_r;
  logic          match;

  logic          found_r;
  logic [IW-1:0] match_idx_r;
  logic [DW-1:0] m_pri_r, m_bak_r;
  logic [TW-1:0] m_stamp_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;

  // write-back decode
  logic          wr_en;
  logic [IW-1:0] wr_slot;
  logic          ptr_adv;
  logic [TW-1:0] age;
  logic          live;

  // result register
  logic          out_valid_r;
  logic          res_hit_r;
  ttlc_pkg::ttlc_outcome_t res_oc_r;
  logic [DW-1:0] res_pri_r, res_bak_r;
  logic          res_hit;
  ttlc_pkg::ttlc_outcome_t res_oc;

  assign issue   = cmd.step && (cnt_r < CW'(EN));
  assign rd_addr = cnt_r[IW-1:0];
  assign match   = rd_en_r && valid_r[rd_idx_r] && (rd_key_r == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= ttlc_pkg::TTL_RESET;
    end else if (cfg_wr_en) begin
      ttl_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= ttlc_pkg::ttlc_kind_t'(in_kind);
      key_r  <= in_lookup_key[KW-1:0];
      pid_r  <= in_primary_id[DW-1:0];
      bid_r  <= in_fallback_id[DW-1:0];
      now_r  <= in_now;
    end
  end

  // scan counter and read pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_en_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r   <= '0;
      rd_en_r <= 1'b0;
    end else begin
      rd_en_r <= issue;
      if (issue) cnt_r <= cnt_r + CW'(1);
    end
  end

  // first valid match and first free slot, lowest index wins
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (match && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= rd_idx_r;
        m_pri_r     <= rd_pri_r;
        m_bak_r     <= rd_bak_r;
        m_stamp_r   <= rd_stamp_r;
      end
      if (issue && !free_found_r && !valid_r[rd_addr]) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_addr;
      end
    end
  end

  // write-back slot selection
  always_comb begin
    wr_en   = 1'b0;
    wr_slot = evict_ptr_r;
    ptr_adv = 1'b0;
    if (kind_r == ttlc_pkg::KIND_INSERT) begin
      wr_en = 1'b1;
      if (found_r) begin
        wr_slot = match_idx_r;
      end else if (free_found_r) begin
        wr_slot = free_idx_r;
      end else begin
        ptr_adv = 1'b1;
      end
    end
  end

  // age wraps modulo 2^32
  assign age  = now_r - m_stamp_r;
  assign live = age < ttl_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r   <= rd_addr;
      rd_key_r   <= mem_key[rd_addr];
      rd_pri_r   <= mem_pri[rd_addr];
      rd_bak_r   <= mem_bak[rd_addr];
      rd_stamp_r <= mem_stamp[rd_addr];
    end
    if (cmd.exec && wr_en) begin
      mem_key[wr_slot]   <= key_r;
      mem_pri[wr_slot]   <= pid_r;
      mem_bak[wr_slot]   <= bid_r;
      mem_stamp[wr_slot] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      evict_ptr_r <= '0;
    end else if (cmd.exec) begin
      unique case (kind_r)
        ttlc_pkg::KIND_INSERT: begin
          valid_r[wr_slot] <= 1'b1;
          if (ptr_adv) begin
            evict_ptr_r <= (evict_ptr_r == IW'(EN - 1)) ? '0 : evict_ptr_r + IW'(1);
          end
        end
        ttlc_pkg::KIND_LOOKUP: begin
          if (found_r && !live) valid_r[match_idx_r] <= 1'b0;
        end
        ttlc_pkg::KIND_INVAL: begin
          if (found_r) valid_r[match_idx_r] <= 1'b0;
        end
        ttlc_pkg::KIND_CLEAR: begin
          valid_r     <= '0;
          evict_ptr_r <= '0;
        end
        default: begin
          valid_r <= valid_r;
        end
      endcase
    end
  end

  always_comb begin
    res_hit = 1'b0;
    res_oc  = ttlc_pkg::OC_NONE;
    unique case (kind_r)
      ttlc_pkg::KIND_INSERT: res_oc = found_r ? ttlc_pkg::OC_MATCH : ttlc_pkg::OC_FILL;
      ttlc_pkg::KIND_LOOKUP: begin
        if (found_r) begin
          res_hit = live;
          res_oc  = live ? ttlc_pkg::OC_MATCH : ttlc_pkg::OC_EXPIRED;
        end
      end
      ttlc_pkg::KIND_INVAL:  res_oc = found_r ? ttlc_pkg::OC_MATCH : ttlc_pkg::OC_NONE;
      ttlc_pkg::KIND_CLEAR:  res_oc = ttlc_pkg::OC_MATCH;
      default:               res_oc = ttlc_pkg::OC_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_hit_r <= res_hit;
      res_oc_r  <= res_oc;
      res_pri_r <= res_hit ? m_pri_r : '0;
      res_bak_r <= res_hit ? m_bak_r : '0;
    end
  end

  assign stat.scan_done = (cnt_r == CW'(EN)) && !rd_en_r;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_hit           = res_hit_r;
  assign out_outcome       = res_oc_r;
  assign out_found_primary = ttlc_pkg::ID_FIELD_W'(res_pri_r);
  assign out_found_backup  = ttlc_pkg::ID_FIELD_W'(res_bak_r);

endmodule

[src/ttl_lookup_cache_rr_evict_top.sv]
// ----------------------------------------------------------------------------
// TTL location cache - top level
// Fully associative cache with time-to-live expiry and round-robin eviction.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_ready    | kind, lookup_key, primary_id, fallback_id,
//          |                        | now
//  out     | out_valid / out_ready  | hit, outcome, found_primary, found_backup
//  cfg     | cfg_wr_en              | cfg_wr_data (time_to_live)
//
//  Per request: accept, a scan reading the 16 entries one per cycle through
//  the single store read port, a drain of the compare registers, and a
//  write-back. A result held by out_ready stalls only the write-back;
//  the next beat is accepted while it waits. rst_n is synchronous; it
//  empties the cache and sets time_to_live to 60.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttl_lookup_cache_rr_evict_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [ttlc_pkg::KEY_FIELD_W-1:0] in_lookup_key,
  input  logic [ttlc_pkg::ID_FIELD_W-1:0]  in_primary_id,
  input  logic [ttlc_pkg::ID_FIELD_W-1:0]  in_fallback_id,
  input  logic [ttlc_pkg::TIME_W-1:0]      in_now,
  input  logic                             cfg_wr_en,
  input  logic [ttlc_pkg::TIME_W-1:0]      cfg_wr_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [1:0]                       out_outcome,
  output logic [ttlc_pkg::ID_FIELD_W-1:0]  out_found_primary,
  output logic [ttlc_pkg::ID_FIELD_W-1:0]  out_found_backup
);

  ttlc_pkg::ttlc_cmd_t  cmd;
  ttlc_pkg::ttlc_stat_t stat;

  ttlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttlc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_lookup_key     (in_lookup_key),
    .in_primary_id     (in_primary_id),
    .in_fallback_id    (in_fallback_id),
    .in_now            (in_now),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_outcome       (out_outcome),
    .out_found_primary (out_found_primary),
    .out_found_backup  (out_found_backup)
  );

endmodule

[src/ttlc_chk.sv]
// ----------------------------------------------------------------------------
// TTL location cache - port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ttl_lookup_cache_rr_evict_top_defines.svh"

module ttlc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [1:0]                      out_outcome,
  input logic [ttlc_pkg::ID_FIELD_W-1:0] out_found_primary,
  input logic [ttlc_pkg::ID_FIELD_W-1:0] out_found_backup
);

  // a stalled result beat holds
  `TTLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_outcome) && $stable(out_hit))

  // one request in flight: after an accepted beat the scan blocks input
  `TTLC_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)

  // ids are zero unless the beat is a hit
  `TTLC_ASSERT_IMPL(a_miss_ids_zero, clk, rst_n, out_valid && !out_hit, out_found_primary == '0 && out_found_backup == '0)

  // a hit always reports a match
  `TTLC_ASSERT_IMPL(a_hit_outcome, clk, rst_n, out_valid && out_hit, out_outcome == ttlc_pkg::OC_MATCH)

endmodule

bind ttl_lookup_cache_rr_evict_top ttlc_chk u_ttlc_chk (.*);
